[sv/pwm_pkg.sv]
package pwm_pkg;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_WORD    = 1'b1;

    localparam int SYM_W   = 8;
    localparam int NUM_SYM = 256;
    localparam int IDX_W   = 16;
    // distinct values in one string reach at most NUM_SYM
    localparam int DC_W    = 9;
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic             operation;
        logic             new_pat;
        logic             close_pat;
        logic             last;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] widx;
    } t_cmd;

endpackage

[sv/pwm_in_if.sv]
interface pwm_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] symbol;
    logic       last;

    modport source(output valid, output operation, output symbol, output last, input ready);
    modport sink(input valid, input operation, input symbol, input last, output ready);
endinterface

[sv/pwm_out_if.sv]
interface pwm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_index;
    logic        matched;

    modport source(output valid, output word_index, output matched, input ready);
    modport sink(input valid, input word_index, input matched, output ready);
endinterface

[sv/pattern_word_matcher.sv]
// Matches dictionary words against a pattern by first-occurrence coding: each
// string's characters are renumbered in order of first appearance, and a word
// matches when its code sequence and length equal the stored pattern's. Send
// pattern beats (operation 0) then word beats (operation 1), each string ended
// by last; a word's last beat yields one result with its index since the
// pattern load. The block takes one beat per clock cycle while the result
// side is not stalled, with no gaps between strings; a result is registered
// in the lookup stage, then in the output register. The rate is set by the
// per-beat read-modify-write of the 256-entry character map and the one read
// of the pattern code memory; a pattern code still on its way into memory is
// forwarded so that back-to-back beats never wait. A two-beat command queue
// separates the accepting front end from the coding pipeline, so input keeps
// flowing for two beats while the result side is stalled.
// Patterns longer than MAX_LEN make every following word report no match.
module pattern_word_matcher
    import pwm_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pwm_in_if.sink     i_in,
    pwm_out_if.source  o_out
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd f_cmd;
    t_cmd q_cmd;

    pwm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    pwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pwm_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

[sv/pwm_front.sv]
module pwm_front
    import pwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    pwm_in_if.sink   i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic             r_epn;
    logic             n_epn;
    logic [IDX_W-1:0] r_wc;
    logic [IDX_W-1:0] n_wc;
    logic             is_word;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign is_word    = (i_in.operation == OP_WORD);

    always_comb begin
        o_cmd.operation = i_in.operation;
        o_cmd.new_pat   = !is_word && r_epn;
        // a word beat while a pattern is open ends that pattern
        o_cmd.close_pat = is_word && !r_epn;
        o_cmd.last      = i_in.last;
        o_cmd.symbol    = i_in.symbol;
        o_cmd.widx      = r_wc;

        n_epn = is_word ? 1'b1 : i_in.last;
        n_wc  = r_wc;
        if (!is_word && r_epn) begin
            n_wc = '0;
        end else if (is_word && i_in.last) begin
            n_wc = r_wc + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epn <= 1'b1;
            r_wc  <= '0;
        end else if (o_push) begin
            r_epn <= n_epn;
            r_wc  <= n_wc;
        end
    end

endmodule

[sv/pwm_queue.sv]
module pwm_queue
    import pwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

endmodule

[sv/pwm_back.sv]
module pwm_back
    import pwm_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    pwm_out_if.source  o_out
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN < 2) ? 1 : $clog2(MAX_LEN);
    // a compared code never exceeds its position, which stays below MAX_LEN
    localparam int CW = (MAX_LEN > NUM_SYM) ? SYM_W : AW;
    localparam logic [PW-1:0] LenMax = PW'(MAX_LEN);

    // string state
    logic [NUM_SYM-1:0] r_seen;
    logic               r_fresh;
    logic [PW-1:0]      r_pos;
    logic [DC_W-1:0]    r_dc;
    logic [PW-1:0]      r_plen;
    logic               r_tl;

    logic [CW-1:0] char_mem [NUM_SYM];
    logic [CW-1:0] pat_mem  [MAX_LEN];

    // lookup stage
    logic             r_b_valid;
    logic             r_b_word;
    logic             r_b_last;
    logic             r_b_first;
    logic             r_b_hit;
    logic [CW-1:0]    r_b_newcode;
    logic             r_b_in_range;
    logic             r_b_len_eq;
    logic             r_b_tl;
    logic [IDX_W-1:0] r_b_widx;
    logic             r_b_pat_wr;
    logic [AW-1:0]    r_b_addr;
    logic             r_b_byp;
    logic [CW-1:0]    r_byp_code;
    logic [CW-1:0]    r_char_q;
    logic [CW-1:0]    r_pat_q;
    logic             r_mis;

    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_widx;
    logic             r_o_matched;

    logic             adv;
    logic             fire;
    logic             is_word;
    logic             clr;
    logic             hit;
    logic             below;
    logic             in_range;
    logic             len_eq;
    logic [PW-1:0]    eff_pos;
    logic [PW-1:0]    eff_plen;
    logic [PW-1:0]    pos_after;
    logic [DC_W-1:0]  eff_dc;
    logic [CW-1:0]    newcode;
    logic [AW-1:0]    addr;
    logic [CW-1:0]    b_code;
    logic [CW-1:0]    b_pcode;
    logic             b_mis;

    assign adv   = !r_o_valid || o_out.ready;
    assign fire  = i_q_valid && adv;
    assign o_pop = fire;

    always_comb begin
        is_word   = (i_cmd.operation == OP_WORD);
        // the map clears lazily on the first beat of the next string
        clr       = r_fresh || i_cmd.new_pat || i_cmd.close_pat;
        eff_pos   = clr ? '0 : r_pos;
        eff_dc    = clr ? '0 : r_dc;
        hit       = !clr && r_seen[i_cmd.symbol];
        eff_plen  = i_cmd.close_pat ? r_pos : r_plen;
        below     = (eff_pos < LenMax);
        pos_after = below ? eff_pos + PW'(1) : eff_pos;
        in_range  = (eff_pos < eff_plen);
        len_eq    = (pos_after == eff_plen);
        newcode   = eff_dc[CW-1:0];
        addr      = eff_pos[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_fresh <= 1'b1;
            r_pos   <= '0;
            r_dc    <= '0;
            r_plen  <= '0;
            r_tl    <= 1'b0;
        end else if (fire) begin
            r_seen  <= (clr ? '0 : r_seen) | (NUM_SYM'(1) << i_cmd.symbol);
            r_fresh <= i_cmd.last;
            r_pos   <= pos_after;
            r_dc    <= hit ? eff_dc : eff_dc + DC_W'(1);
            if (!is_word && i_cmd.last) begin
                r_plen <= pos_after;
            end else if (i_cmd.close_pat) begin
                r_plen <= r_pos;
            end
            r_tl <= (i_cmd.new_pat ? 1'b0 : r_tl) || (!is_word && !below);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && !hit) begin
            char_mem[i_cmd.symbol] <= newcode;
        end
        if (fire) begin
            r_char_q <= char_mem[i_cmd.symbol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_b_valid && r_b_pat_wr) begin
            pat_mem[r_b_addr] <= b_code;
        end
        if (fire) begin
            r_pat_q <= pat_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_b_word     <= is_word;
            r_b_last     <= i_cmd.last;
            r_b_first    <= clr;
            r_b_hit      <= hit;
            r_b_newcode  <= newcode;
            r_b_in_range <= in_range;
            r_b_len_eq   <= len_eq;
            r_b_tl       <= r_tl;
            r_b_widx     <= i_cmd.widx;
            r_b_pat_wr   <= !is_word && below;
            r_b_addr     <= addr;
            // pattern code still in flight to the same slot
            r_b_byp      <= r_b_valid && r_b_pat_wr && (r_b_addr == addr);
            r_byp_code   <= b_code;
        end
    end

    always_comb begin
        b_code  = r_b_hit ? r_char_q : r_b_newcode;
        b_pcode = r_b_byp ? r_byp_code : r_pat_q;
        b_mis   = (!r_b_first && r_mis) || !r_b_in_range || (b_code != b_pcode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis <= 1'b0;
        end else if (adv && r_b_valid && r_b_word) begin
            r_mis <= b_mis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_b_valid && r_b_word && r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_widx    <= r_b_widx;
            r_o_matched <= !r_b_tl && !b_mis && r_b_len_eq;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.word_index = r_o_widx;
    assign o_out.matched    = r_o_matched;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= LenMax) && (r_plen <= LenMax))
        else $error("position or pattern length beyond limit");

    a_dc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_fresh && (r_pos < LenMax)) |-> (32'(r_dc) <= 32'(r_pos)))
        else $error("more distinct values than symbols");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_b_valid && r_b_word && r_b_last))
        else $error("result without a closing word beat");

endmodule
